// ===== src/fagc_pkg.sv =====
// Shared types, constants and a helper function of the feedback gain loop.
package fagc_pkg;

    // Field widths
    localparam int SAMPLE_W = 16;
    localparam int GAIN_W   = 24;
    localparam int MAG_W    = 16;
    localparam int POW_W    = 32;
    localparam int LEVEL_W  = 40;
    localparam int RATE_W   = 16;
    localparam int PROD_W   = 42;
    localparam int ROOT_STEPS = 16;
    localparam int STEP_W   = $clog2(ROOT_STEPS);

    // Queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);

    // Stream data widths, padded to whole bytes
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 64;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam logic [CFG_IDX_W-1:0] CFG_COMPLEX_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_GOAL   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RISE_RATE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FALL_RATE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_CEILING = 3'd4;

    // Reset values
    localparam logic [GAIN_W-1:0] GAIN_ONE           = 24'd65536;
    localparam logic [15:0]       TARGET_RESET       = 16'd16384;
    localparam logic [RATE_W-1:0] RATE_RESET         = 16'd655;
    localparam logic [GAIN_W-1:0] GAIN_CEILING_RESET = 24'hFFFFFF;

    typedef struct packed {
        logic              complex_mode;
        logic [15:0]       level_goal;
        logic [RATE_W-1:0] rise_rate;
        logic [RATE_W-1:0] fall_rate;
        logic [GAIN_W-1:0] gain_ceiling;
    } t_cfg;

    // One classified sample handed from front to back
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] si;
        logic signed [SAMPLE_W-1:0] sq;
        logic [MAG_W-1:0]           mag;
    } t_qword;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    typedef struct packed {
        logic [SAMPLE_W-1:0] val;
        logic                clip;
    } t_sat;

    // Round half up by 2^16 and clip to 16 bits signed
    function automatic t_sat sat16(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] s;
        logic signed [PROD_W-17:0] r;
        t_sat res;
        s = p + 42'sd32768;
        r = s[PROD_W-1:16];
        res.val  = r[SAMPLE_W-1:0];
        res.clip = 1'b0;
        if (r > 26'sd32767) begin
            res.val  = 16'h7FFF;
            res.clip = 1'b1;
        end else if (r < -26'sd32768) begin
            res.val  = 16'h8000;
            res.clip = 1'b1;
        end
        return res;
    endfunction

endpackage

// ===== src/feedback_agc_gain_loop_unit.sv =====
// Top level of the feedback gain loop: config registers, front, queue, back.
//
//  channel   dir  handshake                          contents
//  s_axis    in   i_s_axis_tvalid / o_s_axis_tready  sample_i, sample_q
//  m_axis    out  o_m_axis_tvalid / i_m_axis_tready  out_i, out_q, gain_used, saturated
//  cfg       in   i_cfg_we                            register index, write data
//
// Real mode: the front passes a sample straight on; complex mode: it first squares i and q
// and takes the one-bit-per-cycle square root. It takes no new sample until the word is pushed.
// The back runs each word through the gain update chain (apply, level, compare, step multiply, clamp).
// Synchronous active-low reset sets gain to 1.0 and config to defaults.
// A two-word queue lets the front keep measuring while the back or the output stalls.
module feedback_agc_gain_loop_unit (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    // [15:0] sample_i, [31:16] sample_q
    input  logic [fagc_pkg::IN_DATA_W-1:0]        i_s_axis_tdata,
    output logic                                  o_m_axis_tvalid,
    input  logic                                  i_m_axis_tready,
    // [15:0] out_i, [31:16] out_q, [55:32] gain_used, [56] saturated, rest zero
    output logic [fagc_pkg::OUT_DATA_W-1:0]       o_m_axis_tdata,
    input  logic                                  i_cfg_we,
    input  logic [fagc_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [fagc_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    fagc_pkg::t_cfg   r_cfg;
    fagc_pkg::t_qword push_word, pop_word;
    fagc_pkg::t_qstat qstat;
    logic push, pop;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.complex_mode <= 1'b0;
            r_cfg.level_goal   <= fagc_pkg::TARGET_RESET;
            r_cfg.rise_rate    <= fagc_pkg::RATE_RESET;
            r_cfg.fall_rate    <= fagc_pkg::RATE_RESET;
            r_cfg.gain_ceiling <= fagc_pkg::GAIN_CEILING_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                fagc_pkg::CFG_COMPLEX_MODE: r_cfg.complex_mode <= i_cfg_data[0];
                fagc_pkg::CFG_LEVEL_GOAL:   r_cfg.level_goal   <= i_cfg_data[15:0];
                fagc_pkg::CFG_RISE_RATE:    r_cfg.rise_rate    <= i_cfg_data[15:0];
                fagc_pkg::CFG_FALL_RATE:    r_cfg.fall_rate    <= i_cfg_data[15:0];
                fagc_pkg::CFG_GAIN_CEILING: r_cfg.gain_ceiling <= i_cfg_data;
                default: ;
            endcase
        end
    end

    fagc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_si    (i_s_axis_tdata[15:0]),
        .i_sq    (i_s_axis_tdata[31:16]),
        .o_push  (push),
        .o_word  (push_word),
        .i_qstat (qstat)
    );

    fagc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_word  (push_word),
        .i_pop   (pop),
        .o_word  (pop_word),
        .o_stat  (qstat)
    );

    fagc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_qstat (qstat),
        .i_word  (pop_word),
        .o_pop   (pop),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_data  (o_m_axis_tdata)
    );

endmodule

// ===== src/fagc_fifo.sv =====
// Two-entry word queue between the front and the back part.
module fagc_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  fagc_pkg::t_qword    i_word,
    input  logic                i_pop,
    output fagc_pkg::t_qword    o_word,
    output fagc_pkg::t_qstat    o_stat
);

    fagc_pkg::t_qword r_mem [fagc_pkg::QDEPTH];
    logic [fagc_pkg::QPTR_W-1:0] r_wptr, r_rptr;
    logic [fagc_pkg::QPTR_W:0]   r_count;

    logic do_push, do_pop;

    assign o_stat.full  = (r_count == (fagc_pkg::QPTR_W + 1)'(fagc_pkg::QDEPTH));
    assign o_stat.empty = (r_count == '0);
    assign do_push = i_push && !o_stat.full;
    assign do_pop  = i_pop && !o_stat.empty;
    assign o_word  = r_mem[r_rptr];

    // storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_word;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== src/fagc_front.sv =====
// Front part: accepts samples and measures their magnitude.
module fagc_front (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  fagc_pkg::t_cfg                       i_cfg,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic signed [fagc_pkg::SAMPLE_W-1:0] i_si,
    input  logic signed [fagc_pkg::SAMPLE_W-1:0] i_sq,
    output logic                                 o_push,
    output fagc_pkg::t_qword                     o_word,
    input  fagc_pkg::t_qstat                     i_qstat
);

    typedef enum logic [2:0] {
        F_IDLE,
        F_SQI,
        F_SQQ,
        F_ROOT,
        F_PUSH
    } t_fstate;

    t_fstate r_state;
    logic signed [fagc_pkg::SAMPLE_W-1:0] r_si, r_sq;
    logic [fagc_pkg::POW_W-1:0]  r_pow;
    logic [fagc_pkg::POW_W-1:0]  r_acc;
    logic [fagc_pkg::MAG_W-1:0]  r_root;
    logic [fagc_pkg::STEP_W-1:0] r_k;

    logic signed [fagc_pkg::POW_W-1:0] sq_prod;
    logic signed [fagc_pkg::SAMPLE_W:0] neg_si;
    logic [fagc_pkg::MAG_W-1:0] abs_si;
    logic [fagc_pkg::POW_W+1:0] trial;
    logic [fagc_pkg::STEP_W:0]  k_up;

    assign o_ready = (r_state == F_IDLE);
    assign o_push  = (r_state == F_PUSH) && !i_qstat.full;
    assign o_word  = '{si: r_si, sq: r_sq, mag: r_root};

    // absolute value of a real sample
    assign neg_si = -{i_si[fagc_pkg::SAMPLE_W-1], i_si};
    assign abs_si = i_si[fagc_pkg::SAMPLE_W-1] ? neg_si[fagc_pkg::MAG_W-1:0]
                                                : i_si;

    // one squarer, used for i then q
    assign sq_prod = (r_state == F_SQI) ? r_si * r_si : r_sq * r_sq;

    // root digit trial: (root + 2^k)^2 = acc + root*2^(k+1) + 2^(2k)
    assign k_up  = {1'b0, r_k} + 1'b1;
    assign trial = {2'b00, r_acc}
                 + ({18'd0, r_root} << k_up)
                 + (34'd1 << {r_k, 1'b0});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            case (r_state)
                F_IDLE: begin
                    if (i_valid) begin
                        r_si   <= i_si;
                        r_sq   <= i_sq;
                        r_root <= abs_si;
                        r_state <= i_cfg.complex_mode ? F_SQI : F_PUSH;
                    end
                end
                F_SQI: begin
                    r_pow   <= sq_prod;
                    r_state <= F_SQQ;
                end
                F_SQQ: begin
                    r_pow   <= r_pow + sq_prod;
                    r_acc   <= '0;
                    r_root  <= '0;
                    r_k     <= fagc_pkg::STEP_W'(fagc_pkg::ROOT_STEPS - 1);
                    r_state <= F_ROOT;
                end
                F_ROOT: begin
                    if (trial <= {2'b00, r_pow}) begin
                        r_acc  <= trial[fagc_pkg::POW_W-1:0];
                        r_root <= r_root | (fagc_pkg::MAG_W'(1) << r_k);
                    end
                    r_k <= r_k - 1'b1;
                    if (r_k == '0) begin
                        r_state <= F_PUSH;
                    end
                end
                F_PUSH: begin
                    if (!i_qstat.full) begin
                        r_state <= F_IDLE;
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

endmodule

// ===== src/fagc_back.sv =====
// Back part: applies the gain, updates it and holds the output word.
module fagc_back (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  fagc_pkg::t_cfg                       i_cfg,
    input  fagc_pkg::t_qstat                     i_qstat,
    input  fagc_pkg::t_qword                     i_word,
    output logic                                 o_pop,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic [fagc_pkg::OUT_DATA_W-1:0]      o_data
);

    typedef enum logic [2:0] {
        B_IDLE,
        B_MUL_I,
        B_MUL_Q,
        B_LEVEL,
        B_DIFF,
        B_PROD,
        B_UPD
    } t_bstate;

    t_bstate r_state;
    logic [fagc_pkg::GAIN_W-1:0]         r_gain;
    fagc_pkg::t_qword                    r_word;
    logic signed [fagc_pkg::PROD_W-1:0]  r_p;
    logic [fagc_pkg::SAMPLE_W-1:0]       r_oi, r_oq;
    logic                                r_clip;
    logic                                r_dec;
    logic [fagc_pkg::LEVEL_W-1:0]        r_diff;
    logic [35:0]                         r_ph, r_pl;
    logic                                r_ovalid;
    logic [fagc_pkg::OUT_DATA_W-1:0]     r_odata;

    logic signed [fagc_pkg::SAMPLE_W:0]  mul_a;
    logic signed [fagc_pkg::GAIN_W:0]    mul_b;
    logic signed [fagc_pkg::PROD_W-1:0]  prod;
    fagc_pkg::t_sat                      sat;
    logic [fagc_pkg::LEVEL_W-1:0]        level, tgt;
    logic [fagc_pkg::RATE_W-1:0]         rate;
    logic [56:0]                         step_sum;
    logic [25:0]                         delta;
    logic signed [27:0]                  new_gain;
    logic [fagc_pkg::GAIN_W-1:0]         gain_clamped;
    logic                                out_free, upd_done;

    assign out_free = !r_ovalid || i_ready;
    assign upd_done = (r_state == B_UPD) && out_free;
    assign o_pop    = !i_qstat.empty && ((r_state == B_IDLE) || upd_done);
    assign o_valid  = r_ovalid;
    assign o_data   = r_odata;

    // shared gain multiplier: i, then q, then magnitude
    always_comb begin
        case (r_state)
            B_MUL_I: mul_a = {r_word.si[fagc_pkg::SAMPLE_W-1], r_word.si};
            B_MUL_Q: mul_a = {r_word.sq[fagc_pkg::SAMPLE_W-1], r_word.sq};
            default: mul_a = {1'b0, r_word.mag};
        endcase
    end
    assign mul_b = {1'b0, r_gain};
    assign prod  = mul_a * mul_b;
    assign sat   = fagc_pkg::sat16(r_p);

    // level against target
    assign level = r_p[fagc_pkg::LEVEL_W-1:0];
    assign tgt   = {8'd0, i_cfg.level_goal, 16'd0};
    assign rate  = r_dec ? i_cfg.fall_rate : i_cfg.rise_rate;

    // gain step and clamp
    assign step_sum = ({21'd0, r_ph} << 20) + {21'd0, r_pl};
    assign delta    = step_sum[56:31];
    assign new_gain = r_dec ? $signed({4'd0, r_gain}) - $signed({2'd0, delta})
                            : $signed({4'd0, r_gain}) + $signed({2'd0, delta});
    always_comb begin
        if (new_gain < 28'sd0) begin
            gain_clamped = '0;
        end else if (new_gain > $signed({4'd0, i_cfg.gain_ceiling})) begin
            gain_clamped = i_cfg.gain_ceiling;
        end else begin
            gain_clamped = new_gain[fagc_pkg::GAIN_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_gain   <= fagc_pkg::GAIN_ONE;
            r_ovalid <= 1'b0;
        end else begin
            // output taken and no new word loaded this cycle
            if (r_ovalid && i_ready && !upd_done) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                B_IDLE: begin
                    if (!i_qstat.empty) begin
                        r_word  <= i_word;
                        r_state <= B_MUL_I;
                    end
                end
                B_MUL_I: begin
                    r_p     <= prod;
                    r_state <= B_MUL_Q;
                end
                B_MUL_Q: begin
                    r_oi    <= sat.val;
                    r_clip  <= sat.clip;
                    r_p     <= prod;
                    r_state <= B_LEVEL;
                end
                B_LEVEL: begin
                    if (i_cfg.complex_mode) begin
                        r_oq   <= sat.val;
                        r_clip <= r_clip | sat.clip;
                    end else begin
                        r_oq   <= '0;
                    end
                    r_p     <= prod;
                    r_state <= B_DIFF;
                end
                B_DIFF: begin
                    r_dec   <= level > tgt;
                    r_diff  <= (level > tgt) ? level - tgt : tgt - level;
                    r_state <= B_PROD;
                end
                B_PROD: begin
                    r_ph    <= rate * r_diff[fagc_pkg::LEVEL_W-1:20];
                    r_pl    <= rate * r_diff[19:0];
                    r_state <= B_UPD;
                end
                B_UPD: begin
                    if (out_free) begin
                        r_gain   <= gain_clamped;
                        r_ovalid <= 1'b1;
                        r_odata  <= {7'd0, r_clip, r_gain, r_oq, r_oi};
                        if (!i_qstat.empty) begin
                            r_word  <= i_word;
                            r_state <= B_MUL_I;
                        end else begin
                            r_state <= B_IDLE;
                        end
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

endmodule
